/* hw/rtl/ssp_pkg.sv */
// Package for the synchronous serial port: payload structs, action codes and mode codes.
// No dependencies.
`timescale 1ns / 1ps
package ssp_pkg;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WRBUF = 2'd1,
      ACT_RDBUF = 2'd2,
      ACT_WRC2  = 2'd3
   } action_type;

   localparam logic [3:0] MODE_SPI_MAX = 4'd3;
   localparam logic [3:0] MODE_SPI_SLV = 4'd5;
   localparam logic [3:0] MODE_I2C     = 4'd8;

   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_MODE   = 2'd1;
   localparam logic [1:0] CSR_BAUD   = 2'd2;

   localparam int C2_SEN     = 0;
   localparam int C2_RSEN    = 1;
   localparam int C2_PEN     = 2;
   localparam int C2_RCEN    = 3;
   localparam int C2_ACKEN   = 4;
   localparam int C2_ACKDT   = 5;
   localparam int C2_ACKSTAT = 6;

   localparam logic [3:0] STOP_BITS = 4'd11;

   typedef struct packed {
      action_type  action;
      logic [7:0]  write_data;
      logic        sck_in;
      logic        sdi_in;
   } req_type;

   typedef struct packed {
      logic        sck_level;
      logic        sck_drive;
      logic        sdo_level;
      logic        sda_level;
      logic        sda_drive;
      logic [7:0]  read_data;
      logic        buffer_full;
      logic        transmit_busy;
      logic [7:0]  control2_bits;
      logic        interrupt_set;
   } rsp_type;

endpackage

/* hw/rtl/spi_i2c_sync_serial_port.sv */
// Top level of the synchronous serial port: SPI master/slave and I2C master.
// A result appears the cycle after its accept; one per cycle unless rsp_ready stalls.
// The next state is computed in one pass and registered with the result.
// Reset clears all port state, config registers and the result valid.
// Depends on ssp_pkg.
`timescale 1ns / 1ps
module spi_i2c_sync_serial_port
   import ssp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic       enable_ff;
   logic [3:0] mode_ff;
   logic [7:0] baud_ff;

   logic [8:0] phase_ff, phase_in;
   logic       prev_ff, prev_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bitc_ff, bitc_in;
   logic [2:0] pend_ff, pend_in;
   logic [7:0] buf_ff, buf_in;
   logic       bf_ff, bf_in, rw_ff, rw_in;
   logic [7:0] c2_ff, c2_in;
   logic       psck_ff, psck_in, psdo_ff, psdo_in, psda_ff, psda_in;
   logic       dsck_ff, dsck_in, dsda_ff, dsda_in;
   logic       irq;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   logic       accept;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic bit_at(input logic [7:0] b, input logic signed [5:0] pos);
      logic r;
      r = 1'b0;
      if (pos >= 0 && pos <= 7) r = b[pos[2:0]];
      return r;
   endfunction

   always_comb begin
      logic       sckn, sdan;
      logic [8:0] mid;
      logic [3:0] bm1;
      sckn = 1'b0; sdan = 1'b0; bm1 = 4'd0;
      phase_in = phase_ff; prev_in = prev_ff; shift_in = shift_ff; bitc_in = bitc_ff;
      pend_in = pend_ff; buf_in = buf_ff; bf_in = bf_ff; rw_in = rw_ff; c2_in = c2_ff;
      psck_in = psck_ff; psdo_in = psdo_ff; psda_in = psda_ff;
      dsck_in = dsck_ff; dsda_in = dsda_ff;
      irq = 1'b0;
      mid = ({1'b0, baud_ff} + 9'd1) >> 1;
      if (req_data.action == ACT_WRBUF) buf_in = req_data.write_data;
      if (req_data.action == ACT_WRC2) c2_in = req_data.write_data;
      if (enable_ff) begin
         if (mode_ff <= MODE_SPI_MAX) begin
            if (req_data.action == ACT_WRBUF) begin
               bitc_in = 4'd8; phase_in = 9'd1; psck_in = 1'b0; dsda_in = 1'b0;
            end
            if (req_data.action == ACT_RDBUF) bf_in = 1'b0;
            if (bitc_in != 4'd0) begin
               bm1 = bitc_in - 4'd1;
               unique case (phase_in)
                  9'd0: begin
                     psck_in = 1'b0; bitc_in = bitc_in - 4'd1;
                  end
                  9'd1: psdo_in = bit_at(buf_in, $signed({2'b00, bm1}));
                  9'd2: begin
                     sdan = dsda_in ? psda_in : req_data.sdi_in;
                     if (bm1 <= 4'd7) shift_in[bm1[2:0]] = shift_in[bm1[2:0]] | sdan;
                     psck_in = 1'b1;
                  end
                  9'd3: phase_in = 9'h1FF;
                  default: ;
               endcase
               phase_in = phase_in + 9'd1;
               if (bitc_in == 4'd0) begin
                  bf_in = 1'b1; irq = 1'b1; buf_in = shift_in; shift_in = 8'd0;
               end
            end
         end else if (mode_ff == MODE_SPI_SLV) begin
            dsda_in = 1'b0;
            if (req_data.action == ACT_RDBUF) bf_in = 1'b0;
            prev_in = phase_in[0];
            sckn = dsck_in ? psck_in : req_data.sck_in;
            phase_in = {8'd0, sckn};
            if (!prev_in && sckn)
               psdo_in = bit_at(buf_in, 6'sd7 - $signed({2'b00, bitc_in}));
            if (prev_in && !sckn) begin
               if (bitc_in <= 4'd7)
                  shift_in[3'd7 - bitc_in[2:0]] = 1'b1 & (shift_in[3'd7 - bitc_in[2:0]] | req_data.sdi_in);
               bitc_in = bitc_in + 4'd1;
            end
            if (bitc_in >= 4'd8) begin
               buf_in = shift_in; shift_in = 8'd0; bf_in = 1'b1; irq = 1'b1; bitc_in = 4'd0;
            end
         end else if (mode_ff == MODE_I2C) begin
            phase_in = phase_in + 9'd1;
            if (phase_in == 9'd1) begin
               if (c2_in[C2_SEN]) begin
                  dsck_in = 1'b1; dsda_in = 1'b1; psda_in = 1'b1; psck_in = 1'b1;
                  pend_in[0] = 1'b1;
               end else if (c2_in[C2_RSEN]) begin
                  dsda_in = 1'b1; psda_in = 1'b1; psck_in = 1'b1; pend_in[1] = 1'b1;
               end else if (c2_in[C2_PEN]) begin
                  dsda_in = 1'b1; psda_in = 1'b0; psck_in = 1'b1; pend_in[2] = 1'b1;
               end
            end
            if (phase_in == mid) begin
               if (c2_in[C2_SEN] && pend_in[0]) begin
                  c2_in[C2_SEN] = 1'b0; dsck_in = 1'b1; psda_in = 1'b0; psck_in = 1'b1;
                  irq = 1'b1; pend_in[0] = 1'b0;
               end else if (c2_in[C2_RSEN] && pend_in[1]) begin
                  c2_in[C2_RSEN] = 1'b0; psda_in = 1'b0; psck_in = 1'b1;
                  irq = 1'b1; pend_in[1] = 1'b0;
               end else if (c2_in[C2_PEN] && pend_in[2]) begin
                  c2_in[C2_PEN] = 1'b0; bitc_in = STOP_BITS; psda_in = 1'b1; psck_in = 1'b1;
                  irq = 1'b1; pend_in[2] = 1'b0;
               end
            end
            if (req_data.action == ACT_WRBUF) begin
               rw_in = 1'b1; bitc_in = 4'd0; dsda_in = 1'b1; bf_in = 1'b1;
            end
            if (!c2_in[C2_RCEN]) prev_in = 1'b0;
            if (c2_in[C2_RCEN] && !prev_in) begin
               bitc_in = 4'd0; buf_in = 8'd0; dsda_in = 1'b0; bf_in = 1'b0; prev_in = 1'b1;
            end
            if (phase_in > {1'b0, baud_ff}) begin
               phase_in = 9'd0;
               if (rw_in && bitc_in < 4'd10) begin
                  if (!(dsck_in ? psck_in : req_data.sck_in)) begin
                     if (bitc_in < 4'd8) psda_in = buf_in[3'd7 - bitc_in[2:0]];
                     bitc_in = bitc_in + 4'd1;
                  end
                  psck_in = !(dsck_in ? psck_in : req_data.sck_in);
                  sckn = dsck_in ? psck_in : req_data.sck_in;
                  if (!sckn && bitc_in == 4'd8) dsda_in = 1'b0;
                  if (sckn && bitc_in == 4'd9)
                     c2_in[C2_ACKSTAT] = dsda_in ? psda_in : req_data.sdi_in;
                  if (!sckn && bitc_in == 4'd9) begin
                     rw_in = 1'b0; bf_in = 1'b0; irq = 1'b1; bitc_in = bitc_in + 4'd1;
                  end
               end
               if ((c2_in[C2_RCEN] || c2_in[C2_ACKEN]) && bitc_in <= 4'd11) begin
                  if ((dsck_in ? psck_in : req_data.sck_in) && bitc_in <= 4'd8) begin
                     bitc_in = bitc_in + 4'd1;
                     sdan = dsda_in ? psda_in : req_data.sdi_in;
                     if (bitc_in >= 4'd1 && bitc_in <= 4'd8)
                        buf_in[3'd0 - bitc_in[2:0]] = buf_in[3'd0 - bitc_in[2:0]] | sdan;
                     if (bitc_in == 4'd8) begin
                        c2_in[C2_ACKEN] = 1'b0; c2_in[C2_RCEN] = 1'b0; irq = 1'b1;
                        bitc_in = bitc_in + 4'd1; bf_in = 1'b1;
                     end
                  end
                  sckn = dsck_in ? psck_in : req_data.sck_in;
                  if (bitc_in <= 4'd8 || (bitc_in == 4'd9 && sckn) || bitc_in > 4'd9)
                     psck_in = !sckn;
                  sckn = dsck_in ? psck_in : req_data.sck_in;
                  if (!sckn && bitc_in > 4'd9) begin
                     irq = 1'b1; bitc_in = bitc_in + 4'd1; c2_in[C2_ACKEN] = 1'b0;
                  end
                  if (c2_in[C2_ACKEN] && !sckn && bitc_in > 4'd8) begin
                     dsda_in = 1'b1; psda_in = c2_in[C2_ACKDT]; bitc_in = bitc_in + 4'd1;
                  end
                  if (bitc_in == STOP_BITS) dsda_in = 1'b0;
               end
            end
         end else begin
            phase_in = phase_in + 9'd1;
         end
      end else begin
         phase_in = 9'd0; prev_in = 1'b0; bitc_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0; mode_ff <= 4'd0; baud_ff <= 8'd0;
         phase_ff <= '0; prev_ff <= 1'b0; shift_ff <= '0; bitc_ff <= '0;
         pend_ff <= '0; buf_ff <= '0; bf_ff <= 1'b0; rw_ff <= 1'b0; c2_ff <= '0;
         psck_ff <= 1'b0; psdo_ff <= 1'b0; psda_ff <= 1'b0;
         dsck_ff <= 1'b0; dsda_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_ENABLE: enable_ff <= csr_data[0];
               CSR_MODE:   mode_ff   <= csr_data[3:0];
               CSR_BAUD:   baud_ff   <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff <= phase_in; prev_ff <= prev_in; shift_ff <= shift_in; bitc_ff <= bitc_in;
            pend_ff <= pend_in; buf_ff <= buf_in; bf_ff <= bf_in; rw_ff <= rw_in; c2_ff <= c2_in;
            psck_ff <= psck_in; psdo_ff <= psdo_in; psda_ff <= psda_in;
            dsck_ff <= dsck_in; dsda_ff <= dsda_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.sck_level     <= psck_in;
         rsp_ff.sck_drive     <= dsck_in;
         rsp_ff.sdo_level     <= psdo_in;
         rsp_ff.sda_level     <= psda_in;
         rsp_ff.sda_drive     <= dsda_in;
         rsp_ff.read_data     <= buf_ff;
         rsp_ff.buffer_full   <= bf_in;
         rsp_ff.transmit_busy <= rw_in;
         rsp_ff.control2_bits <= c2_in;
         rsp_ff.interrupt_set <= irq;
      end
   end

endmodule

/* hw/rtl/ssp_checker.sv */
// Port-level checker for the synchronous serial port, bound to the top level.
// Depends on ssp_pkg.
`timescale 1ns / 1ps
module ssp_checker
   import ssp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("not ready while output empty");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid) else $error("no result after transaction");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result without transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind spi_i2c_sync_serial_port ssp_checker u_ssp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

/* sim/tb_top.sv */
// Testbench for spi_i2c_sync_serial_port: directed and random ticks across all port modes.
// Predicts every result with a cycle model of the port and checks it field by field.
// Depends on ssp_pkg and the port RTL.
`timescale 1ns / 1ps
module tb_top;
   import ssp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_ENABLE;
   logic [7:0] csr_data = '0;

   spi_i2c_sync_serial_port u_dut (.*);

   always #4 clock = ~clock;

   // port model state
   logic       m_en;
   logic [3:0] m_mode;
   logic [7:0] m_baud;
   logic [8:0] m_phase;
   logic       m_prev;
   logic [7:0] m_shift;
   logic [3:0] m_bits;
   logic [2:0] m_pend;
   logic [7:0] m_buf;
   logic       m_bf, m_rw;
   logic [7:0] m_c2;
   logic       m_sck, m_sdo, m_sda;
   logic       m_dsck, m_dsda;
   logic       m_irq;
   logic       m_xsck, m_xsdi;

   req_type tick_queue[$];
   rsp_type port_expect[$];
   int   errors = 0;
   int   results_seen = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   recv_hold = 0;
   bit   send_pause = 0;
   longint cycles = 0;

   function automatic logic sck_rd();
      return m_dsck ? m_sck : m_xsck;
   endfunction

   function automatic logic sda_rd();
      return m_dsda ? m_sda : m_xsdi;
   endfunction

   function automatic logic bit_of(logic [7:0] b, int pos);
      if (pos < 0 || pos > 7) return 1'b0;
      return b[pos];
   endfunction

   function automatic logic [7:0] bit_at(logic v, int pos);
      if (pos < 0 || pos > 7) return 8'd0;
      return 8'(v) << pos;
   endfunction

   task automatic step_spi_master(action_type act);
      int p;
      if (act == ACT_WRBUF) begin
         m_bits = 4'd8;
         m_phase = 9'd1;
         m_sck = 1'b0;
         m_dsda = 1'b0;
      end
      if (act == ACT_RDBUF) m_bf = 1'b0;
      if (m_bits != 0) begin
         p = int'(m_bits) - 1;
         case (m_phase)
            9'd0: begin
               m_sck = 1'b0;
               m_bits = m_bits - 4'd1;
            end
            9'd1: m_sdo = bit_of(m_buf, p);
            9'd2: begin
               m_shift = m_shift | bit_at(sda_rd(), p);
               m_sck = 1'b1;
            end
            9'd3: m_phase = 9'h1FF;
            default: ;
         endcase
         m_phase = m_phase + 9'd1;
         if (m_bits == 0) begin
            m_bf = 1'b1;
            m_irq = 1'b1;
            m_buf = m_shift;
            m_shift = '0;
         end
      end
   endtask

   task automatic step_spi_slave(action_type act);
      m_dsda = 1'b0;
      if (act == ACT_RDBUF) m_bf = 1'b0;
      m_prev = m_phase[0];
      m_phase = 9'(sck_rd());
      if (!m_prev && m_phase == 9'd1) m_sdo = bit_of(m_buf, 7 - int'(m_bits));
      if (m_prev && m_phase == 9'd0) begin
         m_shift = m_shift | bit_at(sda_rd(), 7 - int'(m_bits));
         m_bits = m_bits + 4'd1;
      end
      if (m_bits >= 4'd8) begin
         m_buf = m_shift;
         m_shift = '0;
         m_bf = 1'b1;
         m_irq = 1'b1;
         m_bits = '0;
      end
   endtask

   task automatic step_i2c(action_type act);
      m_phase = m_phase + 9'd1;
      if (m_phase == 9'd1) begin
         if (m_c2[C2_SEN]) begin
            m_dsck = 1'b1; m_dsda = 1'b1; m_sda = 1'b1; m_sck = 1'b1;
            m_pend[0] = 1'b1;
         end else if (m_c2[C2_RSEN]) begin
            m_dsda = 1'b1; m_sda = 1'b1; m_sck = 1'b1;
            m_pend[1] = 1'b1;
         end else if (m_c2[C2_PEN]) begin
            m_dsda = 1'b1; m_sda = 1'b0; m_sck = 1'b1;
            m_pend[2] = 1'b1;
         end
      end
      if (m_phase == (9'(m_baud) + 9'd1) / 9'd2) begin
         if (m_c2[C2_SEN] && m_pend[0]) begin
            m_c2[C2_SEN] = 1'b0; m_dsck = 1'b1; m_sda = 1'b0; m_sck = 1'b1;
            m_irq = 1'b1; m_pend[0] = 1'b0;
         end else if (m_c2[C2_RSEN] && m_pend[1]) begin
            m_c2[C2_RSEN] = 1'b0; m_sda = 1'b0; m_sck = 1'b1;
            m_irq = 1'b1; m_pend[1] = 1'b0;
         end else if (m_c2[C2_PEN] && m_pend[2]) begin
            m_c2[C2_PEN] = 1'b0; m_bits = STOP_BITS; m_sda = 1'b1; m_sck = 1'b1;
            m_irq = 1'b1; m_pend[2] = 1'b0;
         end
      end
      if (act == ACT_WRBUF) begin
         m_rw = 1'b1; m_bits = '0; m_dsda = 1'b1; m_bf = 1'b1;
      end
      if (!m_c2[C2_RCEN]) m_prev = 1'b0;
      if (m_c2[C2_RCEN] && !m_prev) begin
         m_bits = '0; m_buf = '0; m_dsda = 1'b0; m_bf = 1'b0; m_prev = 1'b1;
      end
      if (m_phase > 9'(m_baud)) begin
         m_phase = '0;
         if (m_rw && m_bits < 4'd10) begin
            if (!sck_rd()) begin
               if (m_bits < 4'd8) m_sda = bit_of(m_buf, 7 - int'(m_bits));
               m_bits = m_bits + 4'd1;
            end
            m_sck = !sck_rd();
            if (!sck_rd() && m_bits == 4'd8) m_dsda = 1'b0;
            if (sck_rd() && m_bits == 4'd9) m_c2[C2_ACKSTAT] = sda_rd();
            if (!sck_rd() && m_bits == 4'd9) begin
               m_rw = 1'b0; m_bf = 1'b0; m_irq = 1'b1; m_bits = m_bits + 4'd1;
            end
         end
         if ((m_c2[C2_RCEN] || m_c2[C2_ACKEN]) && m_bits <= 4'd11) begin
            if (sck_rd() && m_bits <= 4'd8) begin
               m_bits = m_bits + 4'd1;
               m_buf = m_buf | bit_at(sda_rd(), 8 - int'(m_bits));
               if (m_bits == 4'd8) begin
                  m_c2[C2_ACKEN] = 1'b0; m_c2[C2_RCEN] = 1'b0;
                  m_irq = 1'b1; m_bits = m_bits + 4'd1; m_bf = 1'b1;
               end
            end
            if (m_bits <= 4'd8 || (m_bits == 4'd9 && sck_rd()) || m_bits > 4'd9)
               m_sck = !sck_rd();
            if (!sck_rd() && m_bits > 4'd9) begin
               m_irq = 1'b1; m_bits = m_bits + 4'd1; m_c2[C2_ACKEN] = 1'b0;
            end
            if (m_c2[C2_ACKEN] && !sck_rd() && m_bits > 4'd8) begin
               m_dsda = 1'b1; m_sda = m_c2[C2_ACKDT]; m_bits = m_bits + 4'd1;
            end
            if (m_bits == STOP_BITS) m_dsda = 1'b0;
         end
      end
   endtask

   task automatic predict_tick(req_type t);
      rsp_type r;
      logic [7:0] seen;
      m_xsck = t.sck_in;
      m_xsdi = t.sdi_in;
      m_irq = 1'b0;
      seen = m_buf;
      if (t.action == ACT_WRBUF) m_buf = t.write_data;
      if (t.action == ACT_WRC2) m_c2 = t.write_data;
      if (m_en) begin
         if (m_mode <= MODE_SPI_MAX) step_spi_master(t.action);
         else if (m_mode == MODE_SPI_SLV) step_spi_slave(t.action);
         else if (m_mode == MODE_I2C) step_i2c(t.action);
         else m_phase = m_phase + 9'd1;
      end else begin
         m_phase = '0; m_prev = 1'b0; m_bits = '0;
      end
      r.sck_level = m_sck;
      r.sck_drive = m_dsck;
      r.sdo_level = m_sdo;
      r.sda_level = m_sda;
      r.sda_drive = m_dsda;
      r.read_data = seen;
      r.buffer_full = m_bf;
      r.transmit_busy = m_rw;
      r.control2_bits = m_c2;
      r.interrupt_set = m_irq;
      port_expect.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && req_ready) predict_tick(req_data);
         if (!(req_valid && !req_ready)) begin
            if (tick_queue.size() != 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= tick_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (!reset) begin
         if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (port_expect.size() == 0) begin
            $error("unexpected transaction %p", rsp_data);
            errors++;
         end else begin
            e = port_expect.pop_front();
            if (e.sck_level != rsp_data.sck_level) begin
               $error("sck_level exp %0h got %0h", e.sck_level, rsp_data.sck_level); errors++;
            end
            if (e.sck_drive != rsp_data.sck_drive) begin
               $error("sck_drive exp %0h got %0h", e.sck_drive, rsp_data.sck_drive); errors++;
            end
            if (e.sdo_level != rsp_data.sdo_level) begin
               $error("sdo_level exp %0h got %0h", e.sdo_level, rsp_data.sdo_level); errors++;
            end
            if (e.sda_level != rsp_data.sda_level) begin
               $error("sda_level exp %0h got %0h", e.sda_level, rsp_data.sda_level); errors++;
            end
            if (e.sda_drive != rsp_data.sda_drive) begin
               $error("sda_drive exp %0h got %0h", e.sda_drive, rsp_data.sda_drive); errors++;
            end
            if (e.read_data != rsp_data.read_data) begin
               $error("read_data exp %0h got %0h", e.read_data, rsp_data.read_data); errors++;
            end
            if (e.buffer_full != rsp_data.buffer_full) begin
               $error("buffer_full exp %0h got %0h", e.buffer_full,
                      rsp_data.buffer_full); errors++;
            end
            if (e.transmit_busy != rsp_data.transmit_busy) begin
               $error("transmit_busy exp %0h got %0h", e.transmit_busy,
                      rsp_data.transmit_busy); errors++;
            end
            if (e.control2_bits != rsp_data.control2_bits) begin
               $error("control2_bits exp %0h got %0h", e.control2_bits,
                      rsp_data.control2_bits); errors++;
            end
            if (e.interrupt_set != rsp_data.interrupt_set) begin
               $error("interrupt_set exp %0h got %0h", e.interrupt_set,
                      rsp_data.interrupt_set); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic req_type rand_tick(int wr_pct);
      req_type t;
      int k;
      k = $urandom_range(99);
      t.action = (k < wr_pct) ? ACT_WRBUF : (k < wr_pct + 10) ? ACT_RDBUF :
                 (k < wr_pct + 14) ? ACT_WRC2 : ACT_TICK;
      t.write_data = 8'($urandom);
      t.sck_in = 1'($urandom);
      t.sdi_in = 1'($urandom);
      return t;
   endfunction

   function automatic req_type mk(action_type a, logic [7:0] d, logic s, logic i);
      req_type t;
      t.action = a; t.write_data = d; t.sck_in = s; t.sdi_in = i;
      return t;
   endfunction

   task automatic drain();
      while (tick_queue.size() != 0 || port_expect.size() != 0 || req_valid)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] v);
      @(posedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ENABLE: m_en = v[0];
         CSR_MODE:   m_mode = v[3:0];
         default:    m_baud = v;
      endcase
   endtask

   task automatic run_phase(logic [3:0] mode, logic [7:0] baud, int n);
      int wr;
      req_type t;
      write_reg(CSR_MODE, {4'd0, mode});
      write_reg(CSR_BAUD, baud);
      write_reg(CSR_ENABLE, 8'd1);
      wr = (mode == MODE_I2C) ? 1 : 3;
      // I2C: mostly well-formed start/write/receive/stop sequences
      for (int i = 0; i < n; i++) begin
         if (mode == MODE_I2C && $urandom_range(9) < 7) begin
            case ($urandom_range(4))
               0: t = mk(ACT_WRC2, 8'h01, 1'($urandom), 1'($urandom));
               1: t = mk(ACT_WRC2, 8'h02, 1'($urandom), 1'($urandom));
               2: t = mk(ACT_WRC2, 8'h04, 1'($urandom), 1'($urandom));
               3: t = mk(ACT_WRC2, {2'b0, 1'($urandom), 5'h18}, 1'($urandom),
                         1'($urandom));
               default: t = mk(ACT_WRBUF, 8'($urandom), 1'($urandom), 1'($urandom));
            endcase
            tick_queue.push_back(t);
            repeat ($urandom_range(40, 8)) begin
               tick_queue.push_back(rand_tick(0));
               i++;
            end
         end else begin
            tick_queue.push_back(rand_tick(wr));
         end
      end
      drain();
   endtask

   initial begin
      m_en = 0; m_mode = 0; m_baud = 0; m_phase = 0; m_prev = 0; m_shift = 0;
      m_bits = 0; m_pend = 0; m_buf = 0; m_bf = 0; m_rw = 0; m_c2 = 0;
      m_sck = 0; m_sdo = 0; m_sda = 0; m_dsck = 0; m_dsda = 0; m_irq = 0;
      m_xsck = 0; m_xsdi = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // disabled port: stores still land, read keeps buffer-full
      tick_queue.push_back(mk(ACT_WRBUF, 8'hFF, 1'b1, 1'b1));
      tick_queue.push_back(mk(ACT_RDBUF, 8'h00, 1'b0, 1'b0));
      tick_queue.push_back(mk(ACT_WRC2, 8'h7F, 1'b1, 1'b0));
      tick_queue.push_back(mk(ACT_WRC2, 8'h80, 1'b0, 1'b1));
      tick_queue.push_back(mk(ACT_WRC2, 8'h00, 1'b0, 1'b0));
      drain();
      write_reg(CSR_MODE, 8'd0);
      write_reg(CSR_ENABLE, 8'd1);
      // full SPI master byte, then read clears buffer-full
      tick_queue.push_back(mk(ACT_WRBUF, 8'hA5, 1'b0, 1'b1));
      for (int i = 0; i < 34; i++) tick_queue.push_back(mk(ACT_TICK, 8'h00, 1'b0, i[2]));
      tick_queue.push_back(mk(ACT_RDBUF, 8'h00, 1'b0, 1'b0));
      drain();

      send_idle_pct = 16; recv_idle_pct = 66;
      run_phase(4'd0, 8'd0, 200);
      run_phase(4'd3, 8'd255, 150);
      run_phase(MODE_SPI_SLV, 8'd7, 300);
      send_idle_pct = 66; recv_idle_pct = 16;
      run_phase(MODE_I2C, 8'd1, 300);
      run_phase(MODE_I2C, 8'd6, 300);
      // switch modes without disabling so leftovers carry over
      run_phase(MODE_SPI_SLV, 8'd3, 100);
      send_idle_pct = 0; recv_idle_pct = 0;
      run_phase(MODE_I2C, 8'd0, 200);
      run_phase(4'd15, 8'd128, 100);
      run_phase(4'd2, 8'd10, 150);
      // long receiver stall while ticks keep coming
      recv_hold = 300;
      run_phase(MODE_I2C, 8'd3, 200);
      // sender is held off with a tick queued, then released and drained
      send_pause = 1;
      tick_queue.push_back(rand_tick(5));
      repeat (20) @(posedge clock);
      send_pause = 0;
      drain();
      write_reg(CSR_ENABLE, 8'd0);
      run_phase(4'd4, 8'd255, 50);
      write_reg(CSR_ENABLE, 8'd0);
      repeat (10) @(posedge clock);
      $display("covered SPI master, SPI slave, I2C and idle modes; %0d results checked",
               results_seen);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule

/* spi_i2c_sync_serial_port.f */
hw/rtl/ssp_pkg.sv
hw/rtl/spi_i2c_sync_serial_port.sv
hw/rtl/ssp_checker.sv
sim/tb_top.sv
